@@ rtl/lowest_common_ancestor_lifting_macros.svh @@
// Assertion macros shared by the common-ancestor block.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCA_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LCA_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/lca_pkg.sv @@
// Types and codes for the common-ancestor block.
package lca_pkg;

    localparam int FIELD_W = 10;

    typedef logic [FIELD_W-1:0] t_node_id;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_lca_action;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        t_node_id   node_index;
        t_node_id   parent_index;
        t_node_id   node_depth;
        t_node_id   query_first;
        t_node_id   query_second;
    } t_lca_in;

    typedef struct packed {
        logic     result_kind;
        t_node_id ancestor_node;
    } t_lca_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLD_A,
        ST_BLD_B,
        ST_BLD_C,
        ST_Q_DA,
        ST_Q_DB,
        ST_Q_SWAP,
        ST_LIFT_CHK,
        ST_LIFT_X,
        ST_LIFT_Y,
        ST_Q_HREQ,
        ST_Q_HI,
        ST_S_MID
    } t_lca_state;

endpackage

@@ rtl/lca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lowest_common_ancestor_lifting.sv @@
// Lowest common ancestor by binary lifting over RAM-held parent and depth tables.
//
//  Channel   Ports                          Handshake
//  -------   -----------------------------  ---------------------------------
//  command   i_item (t_lca_in)              start high while busy low
//  result    o_result (t_lca_out)           o_result_valid, one cycle, no stall
//
// A load is taken with busy staying low; it gives no result.
// A build steps each table entry through ST_BLD_A, ST_BLD_B and ST_BLD_C, as
// the single read port of the ancestor RAM must serve two dependent reads.
// A query keeps busy high while it fetches both depths, lifts the deeper node
// by the depth gap and then runs a binary search of up to 11 steps over the
// lift length, reading the ancestor table only for set bits of each lift.
// Synchronous active-low reset clears control only; table contents are kept.
// The result strobe cannot be held off; busy falls in the cycle it is shown.
module lowest_common_ancestor_lifting
    import lca_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_lca_in  i_item,
    output logic     o_result_valid,
    output t_lca_out o_result
);

`include "lowest_common_ancestor_lifting_macros.svh"

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int LVC_W     = $clog2(LIFT_LEVELS + 1);
    localparam int ANC_AW    = LVL_W + NODE_W;
    localparam int ANC_DEPTH = 2 ** ANC_AW;
    localparam int DEP_DEPTH = 2 ** NODE_W;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);
    localparam logic [LVC_W-1:0]  LVL_END   = LVC_W'(LIFT_LEVELS);
    localparam logic [LVC_W-1:0]  LVL_TOP   = LVC_W'(LIFT_LEVELS - 1);

    // Node id inside the stored node range
    function automatic logic f_in_range(input t_node_id node);
        logic [31:0] wide;
        wide = 32'(node);
        return wide < 32'(MAX_NODES);
    endfunction

    // Node id as a table row address
    function automatic logic [NODE_W-1:0] f_row(input t_node_id node);
        logic [31:0] wide;
        wide = 32'(node);
        return wide[NODE_W-1:0];
    endfunction

    t_lca_state         r_state, n_state;
    logic               r_built, n_built;
    logic               r_out_valid, n_out_valid;
    t_lca_out           r_out, n_out;
    t_node_id           r_a, n_a;
    t_node_id           r_b, n_b;
    t_node_id           r_x, n_x;
    t_node_id           r_y, n_y;
    t_node_id           r_k, n_k;
    t_node_id           r_mid, n_mid;
    t_node_id           r_ans, n_ans;
    t_node_id           r_da, n_da;
    logic [LVC_W-1:0]   r_lv, n_lv;
    logic [NODE_W-1:0]  r_i, n_i;
    logic signed [11:0] r_lo, n_lo;
    logic signed [11:0] r_hi, n_hi;
    logic               r_found, n_found;
    logic               r_srch, n_srch;
    logic               r_both, n_both;
    logic               r_anc_oor, n_anc_oor;
    logic               r_dep_oor, n_dep_oor;

    logic               anc_we;
    logic [ANC_AW-1:0]  anc_waddr;
    t_node_id           anc_wdata;
    logic [ANC_AW-1:0]  anc_raddr;
    t_node_id           anc_rdata;
    logic               dep_we;
    logic [NODE_W-1:0]  dep_waddr;
    t_node_id           dep_wdata;
    logic [NODE_W-1:0]  dep_raddr;
    t_node_id           dep_rdata;

    t_node_id           anc_val;
    t_node_id           dep_val;
    logic               accept;
    logic [LVC_W-1:0]   lv_dec;
    logic signed [11:0] lohi_sum;

    lca_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    lca_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (DEP_DEPTH)
    ) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    assign accept   = start && !busy;
    assign anc_val  = r_anc_oor ? '0 : anc_rdata;
    assign dep_val  = r_dep_oor ? '0 : dep_rdata;
    assign lv_dec   = r_lv - LVC_W'(1);
    assign lohi_sum = r_lo + r_hi;

    // Hold state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold working values
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_a       <= n_a;
        r_b       <= n_b;
        r_x       <= n_x;
        r_y       <= n_y;
        r_k       <= n_k;
        r_mid     <= n_mid;
        r_ans     <= n_ans;
        r_da      <= n_da;
        r_lv      <= n_lv;
        r_i       <= n_i;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_found   <= n_found;
        r_srch    <= n_srch;
        r_both    <= n_both;
        r_anc_oor <= n_anc_oor;
        r_dep_oor <= n_dep_oor;
    end

    // Sequence loads, builds and queries
    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_a         = r_a;
        n_b         = r_b;
        n_x         = r_x;
        n_y         = r_y;
        n_k         = r_k;
        n_mid       = r_mid;
        n_ans       = r_ans;
        n_da        = r_da;
        n_lv        = r_lv;
        n_i         = r_i;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_found     = r_found;
        n_srch      = r_srch;
        n_both      = r_both;
        n_anc_oor   = r_anc_oor;
        n_dep_oor   = r_dep_oor;

        anc_we      = 1'b0;
        anc_waddr   = {LVL_W'(0), f_row(i_item.node_index)};
        anc_wdata   = i_item.parent_index;
        anc_raddr   = {r_lv[LVL_W-1:0], f_row(r_x)};
        dep_we      = 1'b0;
        dep_waddr   = f_row(i_item.node_index);
        dep_wdata   = i_item.node_depth;
        dep_raddr   = f_row(r_a);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_lca_action'(i_item.action))
                        ACT_LOAD: begin
                            n_built = 1'b0;
                            if (f_in_range(i_item.node_index)) begin
                                anc_we = 1'b1;
                                dep_we = 1'b1;
                            end
                        end
                        ACT_BUILD: begin
                            n_lv = LVC_W'(1);
                            n_i  = '0;
                            if (LIFT_LEVELS > 1) begin
                                n_state = ST_BLD_A;
                            end else begin
                                n_built     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '{result_kind: KIND_ACK, ancestor_node: '0};
                            end
                        end
                        ACT_QUERY: begin
                            if (r_built) begin
                                n_a     = i_item.query_first;
                                n_b     = i_item.query_second;
                                n_state = ST_Q_DA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Build: read own entry one level down
            ST_BLD_A: begin
                anc_raddr = {lv_dec[LVL_W-1:0], r_i};
                n_anc_oor = 1'b0;
                n_state   = ST_BLD_B;
            end

            // Build: read that ancestor's entry one level down
            ST_BLD_B: begin
                anc_raddr = {lv_dec[LVL_W-1:0], f_row(anc_val)};
                n_anc_oor = !f_in_range(anc_val);
                n_state   = ST_BLD_C;
            end

            // Build: write the new level and advance
            ST_BLD_C: begin
                anc_we    = 1'b1;
                anc_waddr = {r_lv[LVL_W-1:0], r_i};
                anc_wdata = anc_val;
                n_state   = ST_BLD_A;
                if (r_i == LAST_NODE) begin
                    n_i = '0;
                    if (r_lv == LVL_TOP) begin
                        n_built     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = '{result_kind: KIND_ACK, ancestor_node: '0};
                        n_state     = ST_IDLE;
                    end else begin
                        n_lv = r_lv + LVC_W'(1);
                    end
                end else begin
                    n_i = r_i + NODE_W'(1);
                end
            end

            // Query: fetch both depths
            ST_Q_DA: begin
                dep_raddr = f_row(r_a);
                n_dep_oor = !f_in_range(r_a);
                n_state   = ST_Q_DB;
            end

            ST_Q_DB: begin
                n_da      = dep_val;
                dep_raddr = f_row(r_b);
                n_dep_oor = !f_in_range(r_b);
                n_state   = ST_Q_SWAP;
            end

            // Put the deeper node first and lift it by the depth gap
            ST_Q_SWAP: begin
                if (r_da < dep_val) begin
                    n_a = r_b;
                    n_b = r_a;
                    n_x = r_b;
                    n_k = dep_val - r_da;
                end else begin
                    n_x = r_a;
                    n_k = r_da - dep_val;
                end
                n_lv    = '0;
                n_both  = 1'b0;
                n_srch  = 1'b0;
                n_state = ST_LIFT_CHK;
            end

            // Lift: walk the levels, reading only for set bits
            ST_LIFT_CHK: begin
                if ((r_k == '0) || (r_lv == LVL_END)) begin
                    if (!r_srch) begin
                        n_state = ST_Q_HREQ;
                    end else begin
                        if (r_x == r_y) begin
                            n_found = 1'b1;
                            n_ans   = r_x;
                            n_hi    = $signed({2'b00, r_mid}) - 12'sd1;
                        end else begin
                            n_lo = $signed({2'b00, r_mid}) + 12'sd1;
                        end
                        n_state = ST_S_MID;
                    end
                end else if (r_k[0]) begin
                    anc_raddr = {r_lv[LVL_W-1:0], f_row(r_x)};
                    n_anc_oor = !f_in_range(r_x);
                    n_state   = ST_LIFT_X;
                end else begin
                    n_k  = r_k >> 1;
                    n_lv = r_lv + LVC_W'(1);
                end
            end

            ST_LIFT_X: begin
                n_x = anc_val;
                if (r_both) begin
                    anc_raddr = {r_lv[LVL_W-1:0], f_row(r_y)};
                    n_anc_oor = !f_in_range(r_y);
                    n_state   = ST_LIFT_Y;
                end else begin
                    n_k     = r_k >> 1;
                    n_lv    = r_lv + LVC_W'(1);
                    n_state = ST_LIFT_CHK;
                end
            end

            ST_LIFT_Y: begin
                n_y     = anc_val;
                n_k     = r_k >> 1;
                n_lv    = r_lv + LVC_W'(1);
                n_state = ST_LIFT_CHK;
            end

            // Fetch the depth of the lifted node as the search bound
            ST_Q_HREQ: begin
                dep_raddr = f_row(r_x);
                n_dep_oor = !f_in_range(r_x);
                n_a       = r_x;
                n_state   = ST_Q_HI;
            end

            ST_Q_HI: begin
                n_hi    = $signed({2'b00, dep_val});
                n_lo    = '0;
                n_found = 1'b0;
                n_state = ST_S_MID;
            end

            // Binary search over the lift length
            ST_S_MID: begin
                if (r_lo <= r_hi) begin
                    n_mid   = lohi_sum[10:1];
                    n_k     = lohi_sum[10:1];
                    n_x     = r_a;
                    n_y     = r_b;
                    n_lv    = '0;
                    n_both  = 1'b1;
                    n_srch  = 1'b1;
                    n_state = ST_LIFT_CHK;
                end else begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: KIND_ANSWER,
                                    ancestor_node: (r_found ? r_ans : '0)};
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // A result only appears once the sequencer is back at rest
    `LCA_ASSERT_NOW(a_result_at_rest, i_clk, i_rst_n, o_result_valid, r_state == ST_IDLE)
    // An acknowledge carries node zero
    `LCA_ASSERT_NOW(a_ack_zero, i_clk, i_rst_n,
        o_result_valid && (o_result.result_kind == KIND_ACK), o_result.ancestor_node == '0)
    // A query before build is dropped without a result
    `LCA_ASSERT_NEXT(a_query_dropped, i_clk, i_rst_n,
        accept && (i_item.action == ACT_QUERY) && !r_built, !busy && !o_result_valid)
    // A load invalidates the ancestor table
    `LCA_ASSERT_NEXT(a_load_clears_built, i_clk, i_rst_n,
        accept && (i_item.action == ACT_LOAD), !r_built)
    // The lift level never passes the level count
    `LCA_ASSERT_NOW(a_level_bound, i_clk, i_rst_n,
        (r_state == ST_LIFT_CHK) || (r_state == ST_LIFT_X) || (r_state == ST_LIFT_Y),
        r_lv <= LVL_END)

endmodule
